/* sv/i2crm_pkg.sv */
// ---------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants for the register access I2C master.
// ---------------------------------------------------------------------------
package i2crm_pkg;

  // bus command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // half bit period after reset, in ticks
  localparam logic [7:0] HALF_BIT_RESET = 8'd5;

  // one transaction on the input channel: one bus timing tick
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  // one transaction on the result channel
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       write_byte_taken;
    logic [7:0] read_data;
    logic       read_valid;
    logic       ack_valid;
    logic       nack_seen;
    logic       done_res;
  } out_t;

  // bus segment sequencer, one-hot
  typedef enum logic [15:0] {
    PH_IDLE = 16'b0000_0000_0000_0001,
    PH_ST0  = 16'b0000_0000_0000_0010,
    PH_ST1  = 16'b0000_0000_0000_0100,
    PH_ST2  = 16'b0000_0000_0000_1000,
    PH_RS0  = 16'b0000_0000_0001_0000,
    PH_WLO  = 16'b0000_0000_0010_0000,
    PH_WHI  = 16'b0000_0000_0100_0000,
    PH_AK0  = 16'b0000_0000_1000_0000,
    PH_AK1  = 16'b0000_0001_0000_0000,
    PH_RLO  = 16'b0000_0010_0000_0000,
    PH_RHI  = 16'b0000_0100_0000_0000,
    PH_MK0  = 16'b0000_1000_0000_0000,
    PH_MK1  = 16'b0001_0000_0000_0000,
    PH_SP0  = 16'b0010_0000_0000_0000,
    PH_SP1  = 16'b0100_0000_0000_0000,
    PH_SP2  = 16'b1000_0000_0000_0000
  } phase_t;

  // what the byte on the wire is for
  typedef enum logic [1:0] {
    ROLE_ADDR  = 2'd0,
    ROLE_REG   = 2'd1,
    ROLE_RADDR = 2'd2,
    ROLE_DATA  = 2'd3
  } role_t;

endpackage

/* sv/i2crm_engine.sv */
// ---------------------------------------------------------------------------
// i2crm_engine
// Bus sequencer: holds the bus state and works out one tick per step.
// ---------------------------------------------------------------------------
module i2crm_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  i2crm_pkg::in_t  item,
  input  logic [7:0]      half_bit_ticks,
  output i2crm_pkg::out_t result
);
  import i2crm_pkg::*;

  phase_t     phase_r, phase_nxt;
  role_t      role_r, role_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] brem_r, brem_nxt;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  logic       enter_en;
  phase_t     enter_ph;
  logic [7:0] half_m1;
  logic       ack_bit;

  // a zero period behaves as one tick
  assign half_m1 = (half_bit_ticks == 8'd0) ? 8'd0 : half_bit_ticks - 8'd1;

  // next state and this tick's result
  always_comb begin
    phase_nxt     = phase_r;
    role_nxt      = role_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    brem_nxt      = brem_r;
    dev_nxt       = dev_r;
    reg_nxt       = reg_r;
    read_mode_nxt = read_mode_r;
    delay_nxt     = delay_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    enter_en      = 1'b0;
    enter_ph      = PH_IDLE;
    ack_bit       = 1'b0;

    result                  = '0;
    result.scl_out          = scl_r;
    result.sda_out          = sda_r;
    result.busy_res         = (phase_r != PH_IDLE);

    if (phase_r == PH_IDLE) begin
      // begin a transaction from idle
      if (item.command == CMD_WRITE || item.command == CMD_READ) begin
        dev_nxt         = item.device_address;
        reg_nxt         = item.register_address;
        brem_nxt        = item.byte_count;
        read_mode_nxt   = (item.command == CMD_READ);
        role_nxt        = ROLE_ADDR;
        result.busy_res = 1'b1;
        enter_en        = 1'b1;
        enter_ph        = PH_ST0;
      end
    end else if (delay_r != 8'd0) begin
      delay_nxt = delay_r - 8'd1;
    end else begin
      // end of a segment
      case (phase_r)
        PH_ST0: begin enter_en = 1'b1; enter_ph = PH_ST1; end
        PH_ST1: begin enter_en = 1'b1; enter_ph = PH_ST2; end
        PH_ST2: begin
          shift_nxt   = {dev_r, (role_r == ROLE_RADDR)};
          bit_cnt_nxt = 4'd0;
          enter_en    = 1'b1;
          enter_ph    = PH_WLO;
        end
        PH_RS0: begin enter_en = 1'b1; enter_ph = PH_ST0; end
        PH_WLO: begin enter_en = 1'b1; enter_ph = PH_WHI; end
        PH_WHI: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          enter_en    = 1'b1;
          enter_ph    = (bit_cnt_nxt >= 4'd8) ? PH_AK0 : PH_WLO;
        end
        PH_AK0: begin enter_en = 1'b1; enter_ph = PH_AK1; end
        PH_AK1: begin
          result.ack_valid = 1'b1;
          result.nack_seen = item.sda_in;
          enter_en         = 1'b1;
          if (role_r == ROLE_ADDR) begin
            role_nxt    = ROLE_REG;
            shift_nxt   = reg_r;
            bit_cnt_nxt = 4'd0;
            enter_ph    = PH_WLO;
          end else if (role_r == ROLE_RADDR) begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            enter_ph    = (brem_r == 8'd0) ? PH_SP0 : PH_RLO;
          end else if (role_r == ROLE_REG && read_mode_r) begin
            role_nxt = ROLE_RADDR;
            enter_ph = PH_RS0;
          end else if (brem_r == 8'd0) begin
            enter_ph = PH_SP0;
          end else begin
            // take the next write byte
            role_nxt                = ROLE_DATA;
            brem_nxt                = brem_r - 8'd1;
            shift_nxt               = item.write_data;
            bit_cnt_nxt             = 4'd0;
            result.write_byte_taken = 1'b1;
            enter_ph                = PH_WLO;
          end
        end
        PH_RLO: begin enter_en = 1'b1; enter_ph = PH_RHI; end
        PH_RHI: begin
          shift_nxt   = {shift_r[6:0], item.sda_in};
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          enter_en    = 1'b1;
          enter_ph    = (bit_cnt_nxt >= 4'd8) ? PH_MK0 : PH_RLO;
        end
        PH_MK0: begin enter_en = 1'b1; enter_ph = PH_MK1; end
        PH_MK1: begin
          result.read_valid = 1'b1;
          result.read_data  = shift_r;
          brem_nxt          = brem_r - 8'd1;
          bit_cnt_nxt       = 4'd0;
          shift_nxt         = 8'd0;
          enter_en          = 1'b1;
          enter_ph          = (brem_nxt == 8'd0) ? PH_SP0 : PH_RLO;
        end
        PH_SP0: begin enter_en = 1'b1; enter_ph = PH_SP1; end
        PH_SP1: begin enter_en = 1'b1; enter_ph = PH_SP2; end
        PH_SP2: begin
          result.done_res = 1'b1;
          phase_nxt       = PH_IDLE;
          delay_nxt       = 8'd0;
          scl_nxt         = 1'b1;
          sda_nxt         = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          delay_nxt = 8'd0;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
        end
      endcase
    end

    // start a new segment: reload the delay and set the line levels
    if (enter_en) begin
      phase_nxt = enter_ph;
      delay_nxt = half_m1;
      ack_bit   = (brem_nxt == 8'd1);
      case (enter_ph)
        PH_ST1:         begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_ST2, PH_SP0: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_RS0, PH_AK0, PH_RLO: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_WLO:         begin scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; end
        PH_WHI:         begin scl_nxt = 1'b1; sda_nxt = shift_nxt[7]; end
        PH_MK0:         begin scl_nxt = 1'b0; sda_nxt = ack_bit; end
        PH_MK1:         begin scl_nxt = 1'b1; sda_nxt = ack_bit; end
        PH_SP1:         begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        default:        begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
      endcase
    end
  end

  // bus state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      role_r      <= ROLE_ADDR;
      bit_cnt_r   <= 4'd0;
      shift_r     <= 8'd0;
      brem_r      <= 8'd0;
      dev_r       <= 7'd0;
      reg_r       <= 8'd0;
      read_mode_r <= 1'b0;
      delay_r     <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      role_r      <= role_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      brem_r      <= brem_nxt;
      dev_r       <= dev_nxt;
      reg_r       <= reg_nxt;
      read_mode_r <= read_mode_nxt;
      delay_r     <= delay_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
    end
  end

endmodule

/* sv/i2c_register_access_master.sv */
// A result is registered: it appears on out_* in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the sequencer step is combinational into the
// output register, and input stalls only while a held result waits on out_stall.
// Reset (synchronous, rst_n low): bus idle with SCL and SDA released, no result
// held, half_bit_ticks back to 5.
// ---------------------------------------------------------------------------
// i2c_register_access_master
// Register write/read I2C master, stepped once per bus timing tick.
// ---------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2crm_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2crm_pkg::out_t  out_data,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);
  import i2crm_pkg::*;

  logic [7:0] half_bit_r;
  logic       out_valid_r;
  out_t       out_data_r;
  out_t       step_res;
  logic       accept;

  // hold input while a finished result is still waiting
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= HALF_BIT_RESET;
    end else if (cfg_wr_en) begin
      half_bit_r <= cfg_wr_data;
    end
  end

  i2crm_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (accept),
    .item           (in_data),
    .half_bit_ticks (half_bit_r),
    .result         (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= step_res;
    end
  end

endmodule
